/* sv/quadratic_root_solver_assert.svh */
// Assertion macros for the quadratic root solver
`ifndef QUADRATIC_ROOT_SOLVER_ASSERT_SVH
`define QUADRATIC_ROOT_SOLVER_ASSERT_SVH

`ifndef SYNTHESIS
`define QRS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define QRS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define QRS_ASSERT_IMP(lbl, ante, cons, msg)
`define QRS_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

/* sv/qrs_pkg.sv */
`timescale 1ns / 1ps
package qrs_pkg;

  localparam int WORD_BITS     = 32;
  localparam int FRACTION_BITS = 16;
  localparam int D_W           = 2 * WORD_BITS + 1;
  localparam int SQ_STEPS      = WORD_BITS + 1;
  localparam int ROOT_W        = SQ_STEPS;
  localparam int SQX_W         = 2 * SQ_STEPS;
  localparam int SQR_W         = ROOT_W + 2;
  localparam int NUM_W         = WORD_BITS + 2;
  localparam int DIVN_W        = NUM_W + FRACTION_BITS;
  localparam int DEN_W         = WORD_BITS + 1;
  localparam int REM_W         = DEN_W;
  localparam int DIV_STEPS     = DIVN_W;

  localparam logic [DIVN_W-1:0] SAT_POS = {{(DIVN_W-WORD_BITS+1){1'b0}}, {(WORD_BITS-1){1'b1}}};
  localparam logic [DIVN_W-1:0] SAT_NEG = {{(DIVN_W-WORD_BITS){1'b0}}, 1'b1,
                                           {(WORD_BITS-1){1'b0}}};

  typedef enum logic [1:0] {
    KIND_ZERO_DEN = 2'd0,
    KIND_TWO_REAL = 2'd1,
    KIND_REPEATED = 2'd2,
    KIND_COMPLEX  = 2'd3
  } kind_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] coef_a;
    logic signed [WORD_BITS-1:0] coef_b;
    logic signed [WORD_BITS-1:0] coef_c;
  } in_t;

  typedef struct packed {
    kind_t                       root_kind;
    logic signed [WORD_BITS-1:0] first_value;
    logic signed [WORD_BITS-1:0] second_value;
    logic                        saturated;
  } out_t;

  typedef struct packed {
    logic                 azero;
    logic                 dneg;
    logic                 dzero;
    logic                 negb_neg;
    logic                 sa;
    logic [WORD_BITS-1:0] mb;
    logic [DEN_W-1:0]     den;
  } side_t;

  typedef struct packed {
    logic [SQX_W-1:0]  x;
    logic [SQR_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    side_t             side;
  } sq_t;

  typedef struct packed {
    logic [DIVN_W-1:0] num;
    logic [REM_W-1:0]  rem;
    logic [DIVN_W-1:0] quo;
    logic              neg;
  } lane_t;

  typedef struct packed {
    kind_t            kind;
    logic [DEN_W-1:0] den;
    lane_t [1:0]      lane;
  } dv_t;

endpackage

/* sv/qrs_front.sv */
`timescale 1ns / 1ps
module qrs_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  qrs_pkg::in_t  in_data,
  output logic          out_valid,
  output qrs_pkg::sq_t  out_data
);

  localparam int W = qrs_pkg::WORD_BITS;

  logic [W-1:0]   ma, mb, mc;
  logic           s1_valid_r, s1_valid_nxt;
  logic           s1_sa_r, s1_sc_r, s1_czero_r, s1_azero_r, s1_nbneg_r;
  logic [W-1:0]   s1_mb_r, s1_ma_r;
  logic [2*W-1:0] s1_bb_r, s1_ac_r;
  logic [qrs_pkg::D_W:0] bbx, px, dsum, dab, dba;
  logic [qrs_pkg::D_W-1:0] dmag;
  logic           dneg;
  logic           s2_valid_r;
  qrs_pkg::sq_t   s2_r, s2_nxt;

  always_comb begin
    ma = in_data.coef_a[W-1] ? (~in_data.coef_a + W'(1)) : in_data.coef_a;
    mb = in_data.coef_b[W-1] ? (~in_data.coef_b + W'(1)) : in_data.coef_b;
    mc = in_data.coef_c[W-1] ? (~in_data.coef_c + W'(1)) : in_data.coef_c;
    s1_valid_nxt = en ? in_valid : s1_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      if (en) s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_sa_r    <= in_data.coef_a[W-1];
      s1_sc_r    <= in_data.coef_c[W-1];
      s1_czero_r <= (mc == '0);
      s1_azero_r <= (ma == '0);
      s1_nbneg_r <= !in_data.coef_b[W-1] && (mb != '0);
      s1_mb_r    <= mb;
      s1_ma_r    <= ma;
      s1_bb_r    <= {{W{1'b0}}, mb} * {{W{1'b0}}, mb};
      s1_ac_r    <= {{W{1'b0}}, ma} * {{W{1'b0}}, mc};
      s2_r       <= s2_nxt;
    end
  end

  // discriminant as sign and magnitude
  always_comb begin
    bbx  = {{(qrs_pkg::D_W+1-2*W){1'b0}}, s1_bb_r};
    px   = {s1_ac_r, 2'b00};
    dsum = bbx + px;
    dab  = bbx - px;
    dba  = px - bbx;
    if (s1_sa_r != s1_sc_r || s1_czero_r) begin
      dneg = 1'b0;
      dmag = dsum[qrs_pkg::D_W-1:0];
    end else if (bbx >= px) begin
      dneg = 1'b0;
      dmag = dab[qrs_pkg::D_W-1:0];
    end else begin
      dneg = 1'b1;
      dmag = dba[qrs_pkg::D_W-1:0];
    end
    s2_nxt.x             = {{(qrs_pkg::SQX_W-qrs_pkg::D_W){1'b0}}, dmag};
    s2_nxt.rem           = '0;
    s2_nxt.root          = '0;
    s2_nxt.side.azero    = s1_azero_r;
    s2_nxt.side.dneg     = dneg;
    s2_nxt.side.dzero    = (dmag == '0);
    s2_nxt.side.negb_neg = s1_nbneg_r;
    s2_nxt.side.sa       = s1_sa_r;
    s2_nxt.side.mb       = s1_mb_r;
    s2_nxt.side.den      = {s1_ma_r, 1'b0};
  end

  assign out_valid = s2_valid_r;
  assign out_data  = s2_r;

endmodule

/* sv/qrs_sqrt_cell.sv */
`timescale 1ns / 1ps
module qrs_sqrt_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  qrs_pkg::sq_t  in_data,
  output logic          out_valid,
  output qrs_pkg::sq_t  out_data
);

  localparam int RW = qrs_pkg::SQR_W;

  logic           valid_r;
  qrs_pkg::sq_t   data_r, data_nxt;
  logic [RW+1:0]  t, trial, diff;
  logic           take;

  // one root bit per cell: bring down the next pair of radicand bits
  always_comb begin
    t     = {in_data.rem, in_data.x[qrs_pkg::SQX_W-1 -: 2]};
    trial = {{(RW-qrs_pkg::ROOT_W){1'b0}}, in_data.root, 2'b01};
    diff  = t - trial;
    take  = (t >= trial);
    data_nxt      = in_data;
    data_nxt.x    = {in_data.x[qrs_pkg::SQX_W-3:0], 2'b00};
    data_nxt.rem  = take ? diff[RW-1:0] : t[RW-1:0];
    data_nxt.root = {in_data.root[qrs_pkg::ROOT_W-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) data_r <= data_nxt;
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

/* sv/qrs_div_cell.sv */
`timescale 1ns / 1ps
module qrs_div_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  qrs_pkg::dv_t  in_data,
  output logic          out_valid,
  output qrs_pkg::dv_t  out_data
);

  localparam int NW = qrs_pkg::DIVN_W;
  localparam int RW = qrs_pkg::REM_W;

  logic           valid_r;
  qrs_pkg::dv_t   data_r, data_nxt;
  logic [RW:0]    r2 [2];
  logic [RW:0]    rd [2];
  logic [1:0]     qb;

  // one quotient bit per lane per cell, restoring
  always_comb begin
    data_nxt = in_data;
    for (int i = 0; i < 2; i++) begin
      r2[i] = {in_data.lane[i].rem, in_data.lane[i].num[NW-1]};
      rd[i] = r2[i] - {1'b0, in_data.den};
      qb[i] = (r2[i] >= {1'b0, in_data.den});
      data_nxt.lane[i].num = {in_data.lane[i].num[NW-2:0], 1'b0};
      data_nxt.lane[i].rem = qb[i] ? rd[i][RW-1:0] : r2[i][RW-1:0];
      data_nxt.lane[i].quo = {in_data.lane[i].quo[NW-2:0], qb[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) data_r <= data_nxt;
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

/* sv/quadratic_root_solver.sv */
`timescale 1ns / 1ps
// Pipeline: 2 front stages, 33 square-root cells, 1 numerator stage, 50 divider
// cells, output register. Throughput: one request per cycle while in_stall is
// low; a two-entry output buffer lets the chain keep moving while one result is
// stalled. Reset (rst_n low, synchronous) empties every stage and the output
// buffer.
`include "quadratic_root_solver_assert.svh"
module quadratic_root_solver (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  qrs_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output qrs_pkg::out_t  out_data
);

  localparam int W  = qrs_pkg::WORD_BITS;
  localparam int NW = qrs_pkg::NUM_W;

  logic en;
  logic         sq_v [qrs_pkg::SQ_STEPS+1];
  qrs_pkg::sq_t sq_d [qrs_pkg::SQ_STEPS+1];
  logic         dv_v [qrs_pkg::DIV_STEPS+1];
  qrs_pkg::dv_t dv_d [qrs_pkg::DIV_STEPS+1];
  logic         nm_valid_r;
  qrs_pkg::dv_t nm_r, nm_nxt;
  qrs_pkg::side_t sd;
  logic signed [NW:0] nb, rt, s1, s2;
  logic [NW:0]    n1, n2;
  logic [NW-1:0]  m1, m2;
  logic [W:0]     r0, r1;
  qrs_pkg::out_t  res, out_r, skid_r;
  logic           out_valid_r, skid_valid_r, out_free;

  function automatic logic [W:0] lane_word(qrs_pkg::lane_t l);
    logic          negq, over;
    logic [W-1:0]  m, lim;
    negq = l.neg && (l.quo != '0);
    over = negq ? (l.quo > qrs_pkg::SAT_NEG) : (l.quo > qrs_pkg::SAT_POS);
    lim  = negq ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    m    = over ? lim : l.quo[W-1:0];
    return {over, negq ? (~m + W'(1)) : m};
  endfunction

  assign en       = !skid_valid_r;
  assign in_stall = skid_valid_r;

  qrs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .out_valid (sq_v[0]),
    .out_data  (sq_d[0])
  );

  for (genvar k = 0; k < qrs_pkg::SQ_STEPS; k++) begin : g_sqrt
    qrs_sqrt_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (sq_v[k]),
      .in_data   (sq_d[k]),
      .out_valid (sq_v[k+1]),
      .out_data  (sq_d[k+1])
    );
  end

  // numerators for the two dividers
  always_comb begin
    sd = sq_d[qrs_pkg::SQ_STEPS].side;
    nb = $signed({{(NW+1-W){1'b0}}, sd.mb});
    if (sd.negb_neg) nb = -nb;
    rt = $signed({{(NW+1-qrs_pkg::ROOT_W){1'b0}}, sq_d[qrs_pkg::SQ_STEPS].root});
    s1 = nb + rt;
    s2 = nb - rt;
    n1 = -s1;
    n2 = -s2;
    m1 = s1[NW] ? n1[NW-1:0] : s1[NW-1:0];
    m2 = s2[NW] ? n2[NW-1:0] : s2[NW-1:0];
    nm_nxt.den = sd.den;
    for (int i = 0; i < 2; i++) begin
      nm_nxt.lane[i].rem = '0;
      nm_nxt.lane[i].quo = '0;
    end
    nm_nxt.lane[0].num = qrs_pkg::DIVN_W'(sd.mb) << qrs_pkg::FRACTION_BITS;
    nm_nxt.lane[0].neg = sd.negb_neg ^ sd.sa;
    nm_nxt.lane[1]     = nm_nxt.lane[0];
    if (sd.azero) begin
      nm_nxt.kind = qrs_pkg::KIND_ZERO_DEN;
    end else if (sd.dneg) begin
      nm_nxt.kind = qrs_pkg::KIND_COMPLEX;
      nm_nxt.lane[1].num = qrs_pkg::DIVN_W'(sq_d[qrs_pkg::SQ_STEPS].root)
                           << qrs_pkg::FRACTION_BITS;
      nm_nxt.lane[1].neg = 1'b0;
    end else if (sd.dzero) begin
      nm_nxt.kind = qrs_pkg::KIND_REPEATED;
    end else begin
      nm_nxt.kind = qrs_pkg::KIND_TWO_REAL;
      nm_nxt.lane[0].num = qrs_pkg::DIVN_W'(m1) << qrs_pkg::FRACTION_BITS;
      nm_nxt.lane[0].neg = s1[NW] ^ sd.sa;
      nm_nxt.lane[1].num = qrs_pkg::DIVN_W'(m2) << qrs_pkg::FRACTION_BITS;
      nm_nxt.lane[1].neg = s2[NW] ^ sd.sa;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nm_valid_r <= 1'b0;
    end else if (en) begin
      nm_valid_r <= sq_v[qrs_pkg::SQ_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) nm_r <= nm_nxt;
  end

  assign dv_v[0] = nm_valid_r;
  assign dv_d[0] = nm_r;

  for (genvar k = 0; k < qrs_pkg::DIV_STEPS; k++) begin : g_div
    qrs_div_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (dv_v[k]),
      .in_data   (dv_d[k]),
      .out_valid (dv_v[k+1]),
      .out_data  (dv_d[k+1])
    );
  end

  // clamp, sign and pack; a zero denominator gives all zeros
  always_comb begin
    r0 = lane_word(dv_d[qrs_pkg::DIV_STEPS].lane[0]);
    r1 = lane_word(dv_d[qrs_pkg::DIV_STEPS].lane[1]);
    res.root_kind = dv_d[qrs_pkg::DIV_STEPS].kind;
    if (dv_d[qrs_pkg::DIV_STEPS].kind == qrs_pkg::KIND_ZERO_DEN) begin
      res.first_value  = '0;
      res.second_value = '0;
      res.saturated    = 1'b0;
    end else begin
      res.first_value  = r0[W-1:0];
      res.second_value = r1[W-1:0];
      res.saturated    = r0[W] | r1[W];
    end
    out_free = !out_valid_r || !out_stall;
  end

  // output register with a skid entry behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r  <= skid_valid_r | dv_v[qrs_pkg::DIV_STEPS];
      skid_valid_r <= 1'b0;
    end else if (!skid_valid_r) begin
      skid_valid_r <= dv_v[qrs_pkg::DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_r <= skid_valid_r ? skid_r : res;
    end else if (!skid_valid_r) begin
      skid_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `QRS_ASSERT_IMP(a_skid_behind_out, skid_valid_r, out_valid_r, "skid full with output empty")
  `QRS_ASSERT_NXT(a_skid_needs_stall, !out_valid_r, !skid_valid_r, "skid filled without stall")
  `QRS_ASSERT_IMP(a_zero_den_clear, out_valid_r && out_r.root_kind == qrs_pkg::KIND_ZERO_DEN, out_r.first_value == '0 && out_r.second_value == '0 && !out_r.saturated, "zero denominator result not cleared")
  `QRS_ASSERT_IMP(a_imag_nonneg, out_valid_r && out_r.root_kind == qrs_pkg::KIND_COMPLEX, !out_r.second_value[W-1], "negative imaginary magnitude")

endmodule

/* bench/quadratic_root_solver_tb.sv */
`timescale 1ns / 1ps
module quadratic_root_solver_tb;

  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 200;
  localparam int LONG_HOLD    = 400;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  qrs_pkg::in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  qrs_pkg::out_t out_data;

  qrs_pkg::in_t  coef_q[$];
  qrs_pkg::out_t root_q[$];
  logic took = 1'b0;
  int   send_gap = 0;
  int   stall_gap = 0;
  int   hold_cnt = 0;
  logic hold_req = 1'b0;
  logic hold_done = 1'b0;
  logic quiet = 1'b0;
  int   cycles = 0;
  int   errors = 0;
  int   n_sent = 0;
  int   n_recv = 0;
  int   kind_seen[4] = '{0, 0, 0, 0};
  int   n_sat = 0;

  quadratic_root_solver u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #5 clk = ~clk;

  // (num << FRACTION_BITS) / den, truncated; returns {saturated, value}
  function automatic logic [32:0] scale_div(logic signed [71:0] num, logic den_neg,
                                            logic [33:0] den);
    logic [71:0] mag, q;
    logic neg;
    mag = (num < 0) ? -num : num;
    q = (mag << qrs_pkg::FRACTION_BITS) / {38'd0, den};
    neg = ((num < 0) != den_neg) && (q != 0);
    if (neg) begin
      if (q > 72'h8000_0000) return {1'b1, 32'h8000_0000};
      return {1'b0, -q[31:0]};
    end
    if (q > 72'h7fff_ffff) return {1'b1, 32'h7fff_ffff};
    return {1'b0, q[31:0]};
  endfunction

  function automatic qrs_pkg::out_t solve_roots(qrs_pkg::in_t d);
    logic signed [71:0] a, b, c, dis, nb;
    logic [71:0] dmag, root, cand;
    logic [33:0] den;
    logic [32:0] q1, q2;
    logic sa;
    qrs_pkg::out_t r;
    a = 72'(d.coef_a);
    b = 72'(d.coef_b);
    c = 72'(d.coef_c);
    r = '0;
    r.root_kind = qrs_pkg::KIND_ZERO_DEN;
    if (a == 0) return r;
    sa = (a < 0);
    dis = b * b - 4 * a * c;
    dmag = (dis < 0) ? -dis : dis;
    den = 34'((sa ? -a : a) * 2);
    root = '0;
    for (int i = 34; i >= 0; i--) begin
      cand = root | (72'd1 << i);
      if (cand * cand <= dmag) root = cand;
    end
    nb = -b;
    if (dis < 0) begin
      r.root_kind = qrs_pkg::KIND_COMPLEX;
      q1 = scale_div(nb, sa, den);
      q2 = scale_div($signed(root), 1'b0, den);
    end else if (dis == 0) begin
      r.root_kind = qrs_pkg::KIND_REPEATED;
      q1 = scale_div(nb, sa, den);
      q2 = q1;
    end else begin
      r.root_kind = qrs_pkg::KIND_TWO_REAL;
      q1 = scale_div(nb + $signed(root), sa, den);
      q2 = scale_div(nb - $signed(root), sa, den);
    end
    r.first_value = q1[31:0];
    r.second_value = q2[31:0];
    r.saturated = q1[32] | q2[32];
    return r;
  endfunction

  function automatic qrs_pkg::in_t coefs(logic [31:0] a, logic [31:0] b, logic [31:0] c);
    qrs_pkg::in_t t;
    t.coef_a = a;
    t.coef_b = b;
    t.coef_c = c;
    return t;
  endfunction

  function automatic qrs_pkg::in_t random_coefs();
    int sel;
    int ra, rr;
    sel = $urandom_range(0, 9);
    case (sel)
      0, 1, 2: return coefs($urandom, $urandom, $urandom);
      3, 4: return coefs($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000,
                         $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000,
                         $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000);
      5: return coefs(32'd0, $urandom, $urandom);
      6, 7: begin
        // perfect square: a(x - r)^2, raw integers kept small
        ra = $signed($urandom_range(0, 400)) - 200;
        if (ra == 0) ra = 1;
        rr = $signed($urandom_range(0, 2000)) - 1000;
        return coefs(ra, -2 * ra * rr, ra * rr * rr);
      end
      default: return coefs($urandom_range(0, 3) == 0 ? 32'h8000_0000 : $urandom,
                            $urandom >> $urandom_range(0, 31),
                            $signed($urandom) >>> $urandom_range(0, 31));
    endcase
  endfunction

  // sender
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || took) begin
        if (send_gap > 0 && !quiet) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (coef_q.size() > 0) begin
          in_data <= coef_q.pop_front();
          in_valid <= 1'b1;
          send_gap <= ($urandom_range(0, 7) == 0) ? $urandom_range(1, 11) : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_cnt > 0) begin
        hold_cnt <= hold_cnt - 1;
        out_stall <= 1'b1;
      end else if (hold_req && !hold_done) begin
        hold_cnt <= LONG_HOLD;
        hold_done <= 1'b1;
        out_stall <= 1'b1;
      end else if (stall_gap > 0 && !quiet) begin
        stall_gap <= stall_gap - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        stall_gap <= ($urandom_range(0, 7) == 0) ? $urandom_range(1, 11) : 0;
      end
    end
  end

  // acceptance and checking
  always @(posedge clk) begin
    qrs_pkg::out_t exp_r;
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("%0t timeout with %0d results outstanding", $time, root_q.size());
      $display("quadratic_root_solver_tb: FAIL");
      $finish;
    end else if (rst_n) begin
      took <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        root_q.push_back(solve_roots(in_data));
        n_sent <= n_sent + 1;
      end
      if (out_valid && !out_stall) begin
        n_recv <= n_recv + 1;
        if (root_q.size() == 0) begin
          $display("%0t unexpected result: actual %h", $time, out_data);
          errors = errors + 1;
        end else begin
          exp_r = root_q.pop_front();
          kind_seen[exp_r.root_kind] <= kind_seen[exp_r.root_kind] + 1;
          if (exp_r.saturated) n_sat <= n_sat + 1;
          if (out_data.root_kind !== exp_r.root_kind) begin
            $display("%0t root_kind: expected %0d actual %0d", $time,
                     exp_r.root_kind, out_data.root_kind);
            errors = errors + 1;
          end
          if (out_data.first_value !== exp_r.first_value) begin
            $display("%0t first_value: expected %h actual %h", $time,
                     exp_r.first_value, out_data.first_value);
            errors = errors + 1;
          end
          if (out_data.second_value !== exp_r.second_value) begin
            $display("%0t second_value: expected %h actual %h", $time,
                     exp_r.second_value, out_data.second_value);
            errors = errors + 1;
          end
          if (out_data.saturated !== exp_r.saturated) begin
            $display("%0t saturated: expected %0b actual %0b", $time,
                     exp_r.saturated, out_data.saturated);
            errors = errors + 1;
          end
        end
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    coef_q.push_back(coefs(32'd0, 32'd0, 32'd0));
    coef_q.push_back(coefs(32'd0, 32'h7fff_ffff, 32'h8000_0000));
    coef_q.push_back(coefs(32'h0001_0000, 32'd0, 32'd0));
    coef_q.push_back(coefs(32'h0001_0000, 32'hfffe_0000, 32'h0001_0000));
    coef_q.push_back(coefs(32'h0001_0000, 32'd0, 32'h0001_0000));
    coef_q.push_back(coefs(32'h0001_0000, 32'd0, 32'hffff_0000));
    coef_q.push_back(coefs(32'hffff_0000, 32'h0003_0000, 32'h0002_0000));
    coef_q.push_back(coefs(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    coef_q.push_back(coefs(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000));
    coef_q.push_back(coefs(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff));
    coef_q.push_back(coefs(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff));
    coef_q.push_back(coefs(32'h0000_0001, 32'h7fff_ffff, 32'd0));
    coef_q.push_back(coefs(32'hffff_ffff, 32'h8000_0000, 32'd0));
    coef_q.push_back(coefs(32'h0000_0001, 32'h0000_0001, 32'd0));
    coef_q.push_back(coefs(32'h0000_0001, 32'd0, 32'h7fff_ffff));
    coef_q.push_back(coefs(32'h0000_0001, 32'h0000_0002, 32'h0000_0001));
    coef_q.push_back(coefs(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff));
    coef_q.push_back(coefs(32'h0002_0000, 32'h0000_0001, 32'h0000_0001));

    // hold off the sender until the pipe is empty
    wait (coef_q.size() == 0 && !in_valid);
    wait (root_q.size() == 0);

    hold_req <= 1'b1;
    for (int i = 0; i < 430; i++) coef_q.push_back(random_coefs());
    wait (coef_q.size() == 0);
    quiet <= 1'b1;
    for (int i = 0; i < 170; i++) coef_q.push_back(random_coefs());

    wait (coef_q.size() == 0 && !in_valid);
    wait (root_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d requests, checked %0d results; kinds zero/two/rep/cplx %0d/%0d/%0d/%0d",
             n_sent, n_recv, kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3]);
    $display("saturated results %0d, with one long output hold and a drained pause", n_sat);
    if (errors == 0 && root_q.size() == 0) begin
      $display("quadratic_root_solver_tb: PASS");
    end else begin
      $display("quadratic_root_solver_tb: FAIL");
    end
    $finish;
  end

endmodule
